// ===== design/lss_pkg.sv =====
// Shared constants, codes and types for the LIFO stack with search.
// Used by the stack RAM, the controller and the top level.
package lss_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DIST_W      = 8;
    localparam int COUNT_OUT_W = 9;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [DATA_W-1:0]      popped_value;
        logic [DIST_W-1:0]      match_distance;
        logic [DATA_W-1:0]      top_value;
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_result;

endpackage

// ===== design/lss_ram.sv =====
// Single-port-write, single-port-read synchronous store of the stack entries.
// Read data is registered and appears in the cycle after the address. Depends on lss_pkg.
module lss_ram
    import lss_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/lss_ctrl.sv =====
// Sequencer of the stack: fill count, cached top entry and the search walk.
// Drives the stack RAM and hands one result to the output register. Uses lss_pkg.
module lss_ctrl
    import lss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_opcode,
    input  logic [DATA_W-1:0] i_operand_value,
    output logic              o_busy,
    input  logic              i_slot_free,
    output logic              o_res_vld,
    output t_result           o_res,
    output t_ram_req          o_ram_req,
    input  logic [DATA_W-1:0] i_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [DATA_W-1:0] r_top,    n_top;
    logic [DATA_W-1:0] r_val,    n_val;
    logic [ADDR_W-1:0] r_raddr,  n_raddr;
    logic [DIST_W-1:0] r_k,      n_k;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_popped, n_popped;
    logic [DIST_W-1:0] r_dist,   n_dist;

    logic [CNT_W-1:0] w_cnt_m1;
    logic [CNT_W-1:0] w_cnt_m2;

    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_cnt_m2 = r_count - CNT_W'(2);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_top     = r_top;
        n_val     = r_val;
        n_raddr   = r_raddr;
        n_k       = r_k;
        n_status  = r_status;
        n_popped  = r_popped;
        n_dist    = r_dist;
        o_ram_req = '0;
        o_res_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    n_dist   = '0;
                    n_state  = S_FIN;
                    case (i_opcode)
                        OP_PUSH: begin
                            if (r_count == CNT_W'(STACK_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_req.wr_en   = 1'b1;
                                o_ram_req.wr_addr = r_count[ADDR_W-1:0];
                                o_ram_req.wr_data = i_operand_value;
                                n_count = r_count + CNT_W'(1);
                                n_top   = i_operand_value;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_popped = r_top;
                                n_count  = w_cnt_m1;
                                if (r_count != CNT_W'(1)) begin
                                    o_ram_req.rd_en   = 1'b1;
                                    o_ram_req.rd_addr = w_cnt_m2[ADDR_W-1:0];
                                    n_state = S_POP;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                o_ram_req.rd_en   = 1'b1;
                                o_ram_req.rd_addr = w_cnt_m1[ADDR_W-1:0];
                                n_raddr = w_cnt_m1[ADDR_W-1:0];
                                n_k     = '0;
                                n_val   = i_operand_value;
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                n_top   = i_rd_data;
                n_state = S_FIN;
            end
            S_SRCH: begin
                if (i_rd_data == r_val) begin
                    n_dist  = r_k;
                    n_state = S_FIN;
                end else if (r_raddr == '0) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_FIN;
                end else begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_raddr - ADDR_W'(1);
                    n_raddr = r_raddr - ADDR_W'(1);
                    n_k     = (r_k == {DIST_W{1'b1}}) ? r_k : r_k + DIST_W'(1);
                end
            end
            S_FIN: begin
                o_res_vld = 1'b1;
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_val    <= n_val;
        r_raddr  <= n_raddr;
        r_k      <= n_k;
        r_status <= n_status;
        r_popped <= n_popped;
        r_dist   <= n_dist;
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_res.status         = r_status;
        o_res.popped_value   = r_popped;
        o_res.match_distance = r_dist;
        o_res.top_value      = (r_count != '0) ? r_top : '0;
        o_res.is_empty       = (r_count == '0);
        o_res.entry_count    = COUNT_OUT_W'(r_count);
    end

endmodule

// ===== design/lifo_stack_with_search.sv =====
// LIFO stack with search: top level with the output register and assertions.
// Instantiates lss_ctrl and lss_ram; depends on lss_pkg.
//
// Usage: an item on the input channel (i_in_valid, o_in_stall) carries an
// opcode and a signed operand. Push, pop, search and query each give exactly
// one result item on the output channel (o_out_valid, i_out_stall), which
// reports status, the popped value, the match distance, the top entry, an
// empty flag and the entry count after the operation.
// One item is worked on at a time. Push, query and any operation on an empty
// stack or a pop leaving it empty go from acceptance straight to the result;
// a pop that leaves entries first reads the new top back from the RAM. A
// search reads one entry per cycle from the top down until it finds a match
// or has read the bottom entry. The next item is accepted once the result
// register has been loaded.
// Reset empties the stack at once; the entry RAM needs no clearing. While the
// receiver stalls, the result is held and a finished item waits in the
// controller, so the input channel stalls.
module lifo_stack_with_search
    import lss_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_opcode,
    input  logic signed [DATA_W-1:0]      i_operand_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_popped_value,
    output logic [DIST_W-1:0]             o_match_distance,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic                          o_is_empty,
    output logic [COUNT_OUT_W-1:0]        o_entry_count
);

    t_ram_req          w_ram_req;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_busy;
    logic              w_res_vld;
    t_result           w_res;
    logic              w_slot_free;

    logic              r_out_vld;
    t_result           r_out;

    assign w_slot_free = !r_out_vld || !i_out_stall;

    lss_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .o_busy          (w_busy),
        .i_slot_free     (w_slot_free),
        .o_res_vld       (w_res_vld),
        .o_res           (w_res),
        .o_ram_req       (w_ram_req),
        .i_rd_data       (w_rd_data)
    );

    lss_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_slot_free) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_in_stall       = w_busy;
    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_popped_value   = r_out.popped_value;
    assign o_match_distance = r_out.match_distance;
    assign o_top_value      = r_out.top_value;
    assign o_is_empty       = r_out.is_empty;
    assign o_entry_count    = r_out.entry_count;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("controller accepted an item without becoming busy");

    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> w_busy)
        else $error("result offered while the controller is idle");

    a_empty_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_entry_count == '0 && o_top_value == '0))
        else $error("empty result reports entries or a top value");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped from the output register");
`endif

endmodule
